### src/dst_pkg.sv
`default_nettype none

package dst_pkg;

  localparam int WORD_W = 32;
  localparam int FILL_W = 8;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_MOVE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // bit pattern of -1.0
  localparam logic [WORD_W-1:0] EMPTY_WORD = 32'hBF80_0000;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [WORD_W-1:0] push_word;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] popped_word;
    logic [FILL_W-1:0] fill_a;
    logic [FILL_W-1:0] fill_b;
    logic [FILL_W-1:0] dropped;
  } res_t;

endpackage

`default_nettype wire

### src/dst_ram.sv
`default_nettype none

module dst_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/dual_stack_with_transfer_top.sv
`default_nettype none

// Pair of bounded LIFO stacks A and B of 32-bit words, DEPTH entries each.
// A request (push onto A, pop from A, move all of A onto B) is taken at a
// rising edge where start is high and busy is low. Each request gives one
// result, shown on result for exactly one cycle with done high; the
// receiver cannot hold it off, and the next request may be taken in the
// cycle that result is shown.
// Push, pop from an empty A and unused codes: result in the cycle after the
// request, busy stays low.
// Pop from a non-empty A: the synchronous A memory read is issued as the
// request is taken; busy is high in the pop state, which registers the result.
// Move: walks A top first through one read port of A and one write port of
// B, one word a cycle, pipelined across the read latency; the result comes
// once the last word read has been written or dropped, busy until then.
// Words that find B full are dropped and counted in the result.
// Reset clears both fill counts and the control state; memory contents are
// left as they are, since an entry is only read after it has been written.

module dual_stack_with_transfer_top #(
  parameter int DEPTH = 128
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire dst_pkg::req_t req,
  output logic               done,
  output dst_pkg::res_t      result
);

  import dst_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_MOVE = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     count_a;
  logic [CW-1:0]     count_b;
  logic [CW-1:0]     lost;
  logic              pend;
  logic              accept;
  logic [CW-1:0]     count_a_dec;
  logic              a_wr_en;
  logic              a_rd_en;
  logic              b_wr_en;
  logic [WORD_W-1:0] a_rd_data;

  assign busy        = (state != ST_IDLE);
  assign accept      = start && !busy;
  assign count_a_dec = count_a - ONE;

  always_comb begin
    a_wr_en = 1'b0;
    a_rd_en = 1'b0;
    b_wr_en = 1'b0;
    if (accept && req.req_type == REQ_PUSH && count_a != FULL) begin
      a_wr_en = 1'b1;
    end
    if (accept && req.req_type == REQ_POP && count_a != '0) begin
      a_rd_en = 1'b1;
    end
    if (state == ST_MOVE && count_a != '0) begin
      a_rd_en = 1'b1;
    end
    // word read last cycle lands on B unless B is full
    if (state == ST_MOVE && pend && count_b != FULL) begin
      b_wr_en = 1'b1;
    end
  end

  dst_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (count_a[AW-1:0]),
    .wr_data (req.push_word),
    .rd_en   (a_rd_en),
    .rd_addr (count_a_dec[AW-1:0]),
    .rd_data (a_rd_data)
  );

  dst_ram #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (count_b[AW-1:0]),
    .wr_data (a_rd_data),
    .rd_en   (1'b0),
    .rd_addr (count_b[AW-1:0]),
    .rd_data ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count_a <= '0;
      count_b <= '0;
      pend    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            result.popped_word <= '0;
            result.status      <= STAT_OK;
            result.fill_a      <= FILL_W'(count_a);
            result.fill_b      <= FILL_W'(count_b);
            result.dropped     <= '0;
            case (req.req_type)
              REQ_PUSH: begin
                done <= 1'b1;
                if (count_a == FULL) begin
                  result.status <= STAT_FULL;
                end else begin
                  count_a       <= count_a + ONE;
                  result.fill_a <= FILL_W'(count_a + ONE);
                end
              end
              REQ_POP: begin
                if (count_a == '0) begin
                  result.status      <= STAT_EMPTY;
                  result.popped_word <= EMPTY_WORD;
                  done               <= 1'b1;
                end else begin
                  count_a <= count_a_dec;
                  state   <= ST_POP;
                end
              end
              REQ_MOVE: begin
                lost  <= '0;
                pend  <= 1'b0;
                state <= ST_MOVE;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_POP: begin
          result.popped_word <= a_rd_data;
          result.fill_a      <= FILL_W'(count_a);
          done               <= 1'b1;
          state              <= ST_IDLE;
        end
        ST_MOVE: begin
          pend <= (count_a != '0);
          if (count_a != '0) begin
            count_a <= count_a_dec;
          end
          if (pend) begin
            if (count_b != FULL) begin
              count_b <= count_b + ONE;
            end else begin
              lost <= lost + ONE;
            end
          end
          if (count_a == '0 && !pend) begin
            result.fill_a  <= FILL_W'(count_a);
            result.fill_b  <= FILL_W'(count_b);
            result.dropped <= FILL_W'(lost);
            done           <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
